// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define AST_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define AST_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== sv/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// psm_pkg
// types and constants of the primer suffix match search unit
// ----------------------------------------------------------------------------
package psm_pkg;

    localparam int PRIMER_MAX  = 64;
    localparam int SEQ_MAX     = 1048576;
    localparam int ADDR_W      = $clog2(PRIMER_MAX);
    localparam int LEN_W       = $clog2(PRIMER_MAX + 1);
    localparam int POS_W       = $clog2(SEQ_MAX);
    localparam int CNT_W       = $clog2(SEQ_MAX + 1);
    localparam int SYM_W       = 8;
    localparam int IDX_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_PRIMER_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MATCH     = 1'b1;

    localparam logic [CFG_DATA_W-1:0] PRIMER_LENGTH_RESET = 7'd20;
    localparam logic [CFG_DATA_W-1:0] MIN_MATCH_RESET     = 7'd20;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SEQ  = 1'b1;

    typedef enum logic {
        CMD_LOAD,
        CMD_SEQ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   index;
        logic [SYM_W-1:0]   symbol;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] primer_length;
        logic [CFG_DATA_W-1:0] min_match;
    } cfg_t;

    typedef struct packed {
        logic               found;
        logic [LEN_W-1:0]   top_score;
        logic [POS_W-1:0]   best_position;
        logic               overflow;
    } result_t;

    typedef struct packed {
        logic emitting;
        logic scoring;
    } bk_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_EMIT
    } bk_state_t;

endpackage

// ===== sv/psm_ram.sv =====
// ----------------------------------------------------------------------------
// psm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module psm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/psm_front.sv =====
// ----------------------------------------------------------------------------
// psm_front
// accepts input transfers, classifies them and queues commands
// ----------------------------------------------------------------------------
module psm_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_op,
    input  logic [psm_pkg::IDX_W-1:0]  in_index,
    input  logic [psm_pkg::SYM_W-1:0]  in_symbol,
    input  logic                       in_last,
    output logic                       cmd_valid,
    output psm_pkg::cmd_t              cmd,
    input  logic                       cmd_pop
);
    import psm_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              cmd_in;
    logic              push;
    logic              pop;

    // classify the incoming item
    always_comb
    begin
        cmd_in.index  = in_index;
        cmd_in.symbol = in_symbol;
        case (in_op)
            OP_LOAD:
            begin
                cmd_in.kind = CMD_LOAD;
                cmd_in.last = 1'b0;
            end
            default:
            begin
                cmd_in.kind = CMD_SEQ;
                cmd_in.last = in_last;
            end
        endcase
    end

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== sv/psm_back.sv =====
// ----------------------------------------------------------------------------
// psm_back
// executes queued commands: primer writes, window shift and suffix scoring
// ----------------------------------------------------------------------------
module psm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psm_pkg::cfg_t         cfg,
    input  logic                  cmd_valid,
    input  psm_pkg::cmd_t         cmd,
    output logic                  cmd_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output psm_pkg::result_t      out_result,
    output psm_pkg::bk_status_t   status
);
    import psm_pkg::*;

    bk_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   char_count_reg, char_count_next;
    logic [LEN_W-1:0]   kept_score_reg, kept_score_next;
    logic [POS_W-1:0]   kept_pos_reg, kept_pos_next;
    logic               overrun_reg, overrun_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   run_reg, run_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_result_reg, out_result_next;

    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W-1:0]   min_eff;
    logic [LEN_W-1:0]   rd_idx;
    logic [LEN_W-1:0]   run_inc;
    logic [LEN_W-1:0]   score;
    logic               match;

    logic               p_we;
    logic [ADDR_W-1:0]  p_waddr;
    logic [ADDR_W-1:0]  p_raddr;
    logic [SYM_W-1:0]   p_rdata;
    logic               w_we;
    logic [ADDR_W-1:0]  w_raddr;
    logic [SYM_W-1:0]   w_rdata;

    psm_ram #(
        .WIDTH (SYM_W),
        .DEPTH (PRIMER_MAX)
    ) u_primer_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (cmd.symbol),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    psm_ram #(
        .WIDTH (SYM_W),
        .DEPTH (PRIMER_MAX)
    ) u_window_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (head_next),
        .wdata (cmd.symbol),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // clamp the registers to their working range
    always_comb
    begin
        if (cfg.primer_length == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (LEN_W'(cfg.primer_length) > LEN_W'(PRIMER_MAX))
        begin
            len_eff = LEN_W'(PRIMER_MAX);
        end
        else
        begin
            len_eff = LEN_W'(cfg.primer_length);
        end
        min_eff = (cfg.min_match == '0) ? LEN_W'(1) : LEN_W'(cfg.min_match);
    end

    assign run_inc = run_reg + 1'b1;
    assign match   = (p_rdata == w_rdata);
    assign score   = match ? run_inc : run_reg;

    // read addresses: primer from its end, window from the newest character
    assign p_raddr = ADDR_W'(len_eff - LEN_W'(1) - rd_idx);
    assign w_raddr = head_reg - rd_idx[ADDR_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        char_count_next = char_count_reg;
        kept_score_next = kept_score_reg;
        kept_pos_next   = kept_pos_reg;
        overrun_next    = overrun_reg;
        pos_next        = pos_reg;
        run_next        = run_reg;
        last_next       = last_reg;
        out_result_next = out_result_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd_pop         = 1'b0;
        p_we            = 1'b0;
        p_waddr         = ADDR_W'(cmd.index);
        w_we            = 1'b0;
        rd_idx          = run_reg;

        case (state_reg)
            S_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_LOAD:
                        begin
                            p_we = (int'(cmd.index) < PRIMER_MAX);
                        end
                        default:
                        begin
                            head_next = head_reg + 1'b1;
                            w_we      = 1'b1;
                            last_next = cmd.last;
                            if (char_count_reg >= CNT_W'(SEQ_MAX))
                            begin
                                overrun_next = 1'b1;
                                state_next   = cmd.last ? S_EMIT : S_IDLE;
                            end
                            else
                            begin
                                pos_next        = char_count_reg[POS_W-1:0];
                                char_count_next = char_count_reg + 1'b1;
                                if ((char_count_reg + 1'b1) >= CNT_W'(len_eff))
                                begin
                                    run_next   = '0;
                                    state_next = S_READ;
                                end
                                else
                                begin
                                    state_next = cmd.last ? S_EMIT : S_IDLE;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (match && (run_inc != len_eff))
                begin
                    run_next = run_inc;
                    rd_idx   = run_inc;
                end
                else
                begin
                    if ((score > kept_score_reg) && (score >= min_eff))
                    begin
                        kept_score_next = score;
                        kept_pos_next   = POS_W'({1'b0, pos_reg} + (POS_W + 1)'(1)
                                                 - (POS_W + 1)'(len_eff));
                    end
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                = 1'b1;
                    out_result_next.found         = (kept_score_reg != '0);
                    out_result_next.top_score     = kept_score_reg;
                    out_result_next.best_position = kept_pos_reg;
                    out_result_next.overflow      = overrun_reg;
                    char_count_next               = '0;
                    kept_score_next               = '0;
                    kept_pos_next                 = '0;
                    overrun_next                  = 1'b0;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            char_count_reg <= '0;
            kept_score_reg <= '0;
            kept_pos_reg   <= '0;
            overrun_reg    <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            char_count_reg <= char_count_next;
            kept_score_reg <= kept_score_next;
            kept_pos_reg   <= kept_pos_next;
            overrun_reg    <= overrun_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        run_reg        <= run_next;
        out_result_reg <= out_result_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_result      = out_result_reg;
    assign status.emitting = (state_reg == S_EMIT);
    assign status.scoring  = (state_reg == S_READ) || (state_reg == S_CMP);

endmodule

// ===== sv/primer_suffix_match_search_unit.sv =====
// ----------------------------------------------------------------------------
// primer_suffix_match_search_unit
// finds the first window whose primer suffix match is longest
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  primer write or sequence character
//  m_*       out        m_tvalid/m_tready  found, score, position, overflow
//  cfg_*     in         cfg_we             primer_length, min_match
//
//  a primer write or an unscored sequence character is handled straight from idle
//  a scored character goes through a read step, then a compare step that repeats
//  while symbols match, with one read per cycle of the primer and window rams
//  a last character then passes through an emit step that loads the output register
//  reset clears control state only; primer and window rams are not cleared
//  a 2-entry command queue and the output register absorb stalls
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module primer_suffix_match_search_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [psm_pkg::S_TDATA_W-1:0]   s_tdata,   // primer_index, symbol
    input  logic                            s_tuser,   // op
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [psm_pkg::M_TDATA_W-1:0]   m_tdata,   // top_score, best_position
    output logic [psm_pkg::M_TUSER_W-1:0]   m_tuser,   // found, overflow
    input  logic                            cfg_we,
    input  logic [psm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psm_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_pop;
    result_t     result;
    bk_status_t  bk_status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PRIMER_LENGTH: cfg_next.primer_length = cfg_data;
                REG_MIN_MATCH:     cfg_next.min_match     = cfg_data;
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.primer_length <= PRIMER_LENGTH_RESET;
            cfg_reg.min_match     <= MIN_MATCH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_index  (s_tdata[IDX_W-1:0]),
        .in_symbol (s_tdata[IDX_W+SYM_W-1:IDX_W]),
        .in_last   (s_tlast),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    psm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .status     (bk_status)
    );

    assign m_tdata = M_TDATA_W'({result.best_position, result.top_score});
    assign m_tuser = {result.overflow, result.found};

    `AST_IMPLY(a_nohit_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata == '0,
        "result without a hit carries nonzero score or position")
    `AST_IMPLY(a_hit_score, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[LEN_W-1:0] != '0,
        "hit reported with zero score")
    `AST_IMPLY(a_rise_emit, clk, rst_n, $rose(m_tvalid), $past(bk_status.emitting),
        "result appeared outside the emit step")
    `AST_IMPLY(a_no_pop_scoring, clk, rst_n, bk_status.scoring, !cmd_pop,
        "command taken while a window is being scored")

endmodule
